// ===== design/bts_pkg.sv =====
`timescale 1ns / 1ps

package bts_pkg;

	localparam int MAX_DIM_DEF = 256;
	localparam int ADDR_W      = 16;
	localparam int MEM_DEPTH   = 1 << ADDR_W;
	localparam int DIM_W       = 9;
	localparam int FRAC_W      = 16;
	localparam int CFG_IDX_W   = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEX_WIDTH     = 3'd0,
		REG_TEX_HEIGHT    = 3'd1,
		REG_HAS_ALPHA     = 3'd2,
		REG_WRAP_MODE     = 3'd3,
		REG_BILINEAR_MODE = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} opcode_t;

endpackage

// ===== design/bilinear_texture_sampler_core.sv =====
`timescale 1ns / 1ps

// Bilinear texture sampler. An item is taken on every clock at which start is high (busy
// never rises). Opcode write stores one RGBA8 texel; opcode sample returns one filtered
// texel as 8.8 fixed point, strobed by done for one cycle once the item has passed all
// stages, one result per clock at full rate. The five stages are: coordinate scaling,
// address forming, texel RAM read, blend along u, blend along v. The texel store is two
// identical 64K x 32 RAMs, each written with every write and read at two addresses, which
// gives the four neighbours in one cycle. Writes go into the RAMs at the read stage, so a
// sample sees every write taken before it. Texels never written read back undefined.
module bilinear_texture_sampler_core
	import bts_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 opcode,
	input  logic [15:0]          texel_index,
	input  logic [7:0]           in_red,
	input  logic [7:0]           in_green,
	input  logic [7:0]           in_blue,
	input  logic [7:0]           in_alpha,
	input  logic [23:0]          u_coord,
	input  logic [23:0]          v_coord,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	output logic                 done,
	output logic [15:0]          out_red,
	output logic [15:0]          out_green,
	output logic [15:0]          out_blue,
	output logic [15:0]          out_alpha
);

	logic [DIM_W-1:0] tex_width_q, tex_height_q;
	logic             has_alpha_q, wrap_mode_q, bilinear_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q     <= DIM_W'(1);
			tex_height_q    <= DIM_W'(1);
			has_alpha_q     <= 1'b1;
			wrap_mode_q     <= 1'b1;
			bilinear_mode_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEX_WIDTH:     tex_width_q     <= cfg_data;
				REG_TEX_HEIGHT:    tex_height_q    <= cfg_data;
				REG_HAS_ALPHA:     has_alpha_q     <= cfg_data[0];
				REG_WRAP_MODE:     wrap_mode_q     <= cfg_data[0];
				REG_BILINEAR_MODE: bilinear_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective size: zero acts as one, clamp to MAX_DIM
	logic [DIM_W-1:0] w_eff, h_eff;

	always_comb begin
		if (tex_width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (32'(tex_width_q) > MAX_DIM) begin
			w_eff = DIM_W'(MAX_DIM);
		end else begin
			w_eff = tex_width_q;
		end
		if (tex_height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (32'(tex_height_q) > MAX_DIM) begin
			h_eff = DIM_W'(MAX_DIM);
		end else begin
			h_eff = tex_height_q;
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// stage 1: scale fractional coordinates, integer part mod size equals product high bits
	logic [FRAC_W+DIM_W-1:0] pu, pv;
	assign pu = u_coord[FRAC_W-1:0] * w_eff;
	assign pv = v_coord[FRAC_W-1:0] * h_eff;

	logic              vld_s1, op_s1;
	logic [ADDR_W-1:0] widx_s1;
	logic [31:0]       wdata_s1;
	logic [DIM_W-1:0]  x_s1, y_s1;
	logic [FRAC_W-1:0] fu_s1, fv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		op_s1    <= opcode;
		widx_s1  <= texel_index;
		wdata_s1 <= {in_alpha, in_blue, in_green, in_red};
		x_s1     <= pu[FRAC_W+DIM_W-1:FRAC_W];
		y_s1     <= pv[FRAC_W+DIM_W-1:FRAC_W];
		fu_s1    <= bilinear_mode_q ? pu[FRAC_W-1:0] : '0;
		fv_s1    <= bilinear_mode_q ? pv[FRAC_W-1:0] : '0;
	end

	// stage 2: neighbour coordinates and linear addresses
	logic [DIM_W:0]      xp1, yp1;
	logic [DIM_W-1:0]    x1, y1;
	logic                x_over, y_over;
	logic [2*DIM_W-1:0]  yw, y1w;

	assign xp1    = {1'b0, x_s1} + 1'b1;
	assign yp1    = {1'b0, y_s1} + 1'b1;
	assign x_over = (xp1 == {1'b0, w_eff});
	assign y_over = (yp1 == {1'b0, h_eff});
	assign x1     = x_over ? '0 : xp1[DIM_W-1:0];
	assign y1     = y_over ? '0 : yp1[DIM_W-1:0];
	assign yw     = y_s1 * w_eff;
	assign y1w    = y1 * w_eff;

	logic              vld_s2, op_s2;
	logic [ADDR_W-1:0] widx_s2;
	logic [31:0]       wdata_s2;
	logic [ADDR_W-1:0] a00_s2, a10_s2, a01_s2, a11_s2;
	logic              z10_s2, z01_s2, z11_s2;
	logic [FRAC_W-1:0] fu_s2, fv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2    <= op_s1;
		widx_s2  <= widx_s1;
		wdata_s2 <= wdata_s1;
		a00_s2   <= ADDR_W'(yw + {{DIM_W{1'b0}}, x_s1});
		a10_s2   <= ADDR_W'(yw + {{DIM_W{1'b0}}, x1});
		a01_s2   <= ADDR_W'(y1w + {{DIM_W{1'b0}}, x_s1});
		a11_s2   <= ADDR_W'(y1w + {{DIM_W{1'b0}}, x1});
		z10_s2   <= !wrap_mode_q && x_over;
		z01_s2   <= !wrap_mode_q && y_over;
		z11_s2   <= !wrap_mode_q && (x_over || y_over);
		fu_s2    <= fu_s1;
		fv_s2    <= fv_s1;
	end

	// stage 3: texel ram read, writes land here too
	logic [31:0] mem_a [MEM_DEPTH];
	logic [31:0] mem_b [MEM_DEPTH];
	logic        wr_en;
	assign wr_en = vld_s2 && (op_s2 == OP_WRITE);

	logic [31:0] t00_s3, t10_s3, t01_s3, t11_s3;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a[widx_s2] <= wdata_s2;
		end
		t00_s3 <= mem_a[a00_s2];
		t10_s3 <= mem_a[a10_s2];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_b[widx_s2] <= wdata_s2;
		end
		t01_s3 <= mem_b[a01_s2];
		t11_s3 <= mem_b[a11_s2];
	end

	logic              vld_s3;
	logic              z10_s3, z01_s3, z11_s3;
	logic [FRAC_W-1:0] fu_s3, fv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2 && (op_s2 == OP_SAMPLE);
		end
	end

	always_ff @(posedge clk) begin
		z10_s3 <= z10_s2;
		z01_s3 <= z01_s2;
		z11_s3 <= z11_s2;
		fu_s3  <= fu_s2;
		fv_s3  <= fv_s2;
	end

	// stage 4: blend along u
	logic [FRAC_W:0] fu_w, fu_inv, fv_w, fv_inv;
	assign fu_w   = {1'b0, fu_s3};
	assign fu_inv = 17'h10000 - fu_w;

	logic [7:0]  c00 [4];
	logic [7:0]  c10 [4];
	logic [7:0]  c01 [4];
	logic [7:0]  c11 [4];
	logic [24:0] top_s4 [4];
	logic [24:0] bot_s4 [4];
	logic        vld_s4;
	logic [FRAC_W-1:0] fv_s4;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			c00[k] = t00_s3[8*k +: 8];
			c10[k] = z10_s3 ? 8'd0 : t10_s3[8*k +: 8];
			c01[k] = z01_s3 ? 8'd0 : t01_s3[8*k +: 8];
			c11[k] = z11_s3 ? 8'd0 : t11_s3[8*k +: 8];
		end
		// alpha absent reads 255, border still zero
		if (!has_alpha_q) begin
			c00[3] = 8'hFF;
			c10[3] = z10_s3 ? 8'd0 : 8'hFF;
			c01[3] = z01_s3 ? 8'd0 : 8'hFF;
			c11[3] = z11_s3 ? 8'd0 : 8'hFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		fv_s4 <= fv_s3;
		for (int k = 0; k < 4; k++) begin
			top_s4[k] <= 25'(c00[k] * fu_inv) + 25'(c10[k] * fu_w);
			bot_s4[k] <= 25'(c01[k] * fu_inv) + 25'(c11[k] * fu_w);
		end
	end

	// stage 5: blend along v, truncate to 8.8
	assign fv_w   = {1'b0, fv_s4};
	assign fv_inv = 17'h10000 - fv_w;

	logic [41:0] mix [4];
	logic [15:0] res_s5 [4];
	logic        vld_s5;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			mix[k] = 42'(top_s4[k] * fv_inv) + 42'(bot_s4[k] * fv_w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			res_s5[k] <= mix[k][39:24];
		end
	end

	assign done      = vld_s5;
	assign out_red   = res_s5[0];
	assign out_green = res_s5[1];
	assign out_blue  = res_s5[2];
	assign out_alpha = res_s5[3];

	// a result only follows a sample that was taken into the pipeline
	a_done_from_sample: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && (opcode == OP_SAMPLE), 5))
		else $error("result without a matching sample");

	// filtered channels never exceed 255.0
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_red <= 16'hFF00 && out_green <= 16'hFF00 &&
			out_blue <= 16'hFF00 && out_alpha <= 16'hFF00))
		else $error("filtered channel out of range");

	// a write never reaches the blend stages
	a_write_no_blend: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> !vld_s3)
		else $error("write item entered blend path");

endmodule

// ===== sim/bilinear_texture_sampler_core_tb.sv =====
`timescale 1ns / 1ps

module bilinear_texture_sampler_core_tb;
	import bts_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam int DRAIN_CYCLES = 10;

	typedef struct {
		logic [15:0] r, g, b, a;
	} texel8p8_t;

	typedef struct {
		opcode_t     op;
		logic [15:0] idx;
		logic [7:0]  r, g, b, a;
		logic [23:0] u, v;
		bit          typed;
		texel8p8_t   want;
	} vec_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 opcode;
	logic [15:0]          texel_index;
	logic [7:0]           in_red, in_green, in_blue, in_alpha;
	logic [23:0]          u_coord, v_coord;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;
	logic                 done;
	logic [15:0]          out_red, out_green, out_blue, out_alpha;

	logic [31:0] texels [0:MEM_DEPTH-1];
	bit          written [0:MEM_DEPTH-1];
	logic [8:0]  width_r, height_r;
	bit          alpha_r, wrap_r, bilin_r;
	texel8p8_t   pending [$];
	int          n_fail;
	bit          no_gaps;

	vec_t directed [5] = '{
		'{OP_WRITE, 16'h0000, 8'hFF, 8'h00, 8'h80, 8'hFF, 24'h000000, 24'h000000,
			1'b0, '{16'h0, 16'h0, 16'h0, 16'h0}},
		'{OP_WRITE, 16'hFFFF, 8'h00, 8'hFF, 8'h7F, 8'h00, 24'hFFFFFF, 24'hFFFFFF,
			1'b0, '{16'h0, 16'h0, 16'h0, 16'h0}},
		'{OP_SAMPLE, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 24'h000000, 24'h000000,
			1'b1, '{16'hFF00, 16'h0000, 16'h8000, 16'hFF00}},
		'{OP_SAMPLE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF, 24'hFFFFFF,
			1'b1, '{16'hFF00, 16'h0000, 16'h8000, 16'hFF00}},
		'{OP_SAMPLE, 16'h1234, 8'h5A, 8'hA5, 8'h3C, 8'hC3, 24'h008000, 24'h00C000,
			1'b0, '{16'h0, 16'h0, 16'h0, 16'h0}}
	};

	bilinear_texture_sampler_core u_top (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int dim_eff(logic [8:0] d);
		if (d == 0) return 1;
		if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
		return d;
	endfunction

	function automatic void base_texel(input logic [23:0] u, input logic [23:0] v,
			output int x, output int y, output longint fu, output longint fv);
		longint pu, pv;
		pu = longint'(u) * dim_eff(width_r);
		pv = longint'(v) * dim_eff(height_r);
		x  = int'((pu >> 16) % dim_eff(width_r));
		y  = int'((pv >> 16) % dim_eff(height_r));
		fu = pu & 64'hFFFF;
		fv = pv & 64'hFFFF;
	endfunction

	// corner n: bit 0 steps x, bit 1 steps y; returns 0 for a border texel
	function automatic bit corner_addr(int n, int x, int y, output logic [15:0] addr);
		int xx, yy, w, h;
		w  = dim_eff(width_r);
		h  = dim_eff(height_r);
		xx = x + (n & 1);
		yy = y + (n >> 1);
		addr = '0;
		if (xx >= w || yy >= h) begin
			if (!wrap_r) return 1'b0;
			if (xx >= w) xx -= w;
			if (yy >= h) yy -= h;
		end
		addr = 16'(yy * w + xx);
		return 1'b1;
	endfunction

	function automatic texel8p8_t filter_texel(logic [23:0] u, logic [23:0] v);
		int x, y, n, k;
		longint fu, fv, top, bot, mix;
		longint c [4][4];
		logic [15:0] addr;
		logic [15:0] res [4];
		texel8p8_t t;
		base_texel(u, v, x, y, fu, fv);
		for (n = 0; n < 4; n++) begin
			if (corner_addr(n, x, y, addr)) begin
				for (k = 0; k < 4; k++)
					c[n][k] = (k == 3 && !alpha_r) ? 255 : texels[addr][8*k +: 8];
			end else begin
				for (k = 0; k < 4; k++)
					c[n][k] = 0;
			end
		end
		for (k = 0; k < 4; k++) begin
			if (!bilin_r) begin
				res[k] = 16'(c[0][k] << 8);
			end else begin
				top = c[0][k] * (65536 - fu) + c[1][k] * fu;
				bot = c[2][k] * (65536 - fu) + c[3][k] * fu;
				mix = top * (65536 - fv) + bot * fv;
				res[k] = 16'(mix >> 24);
			end
		end
		t.r = res[0];
		t.g = res[1];
		t.b = res[2];
		t.a = res[3];
		return t;
	endfunction

	task automatic send_item(vec_t it);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		opcode      <= it.op;
		texel_index <= it.idx;
		in_red      <= it.r;
		in_green    <= it.g;
		in_blue     <= it.b;
		in_alpha    <= it.a;
		u_coord     <= it.u;
		v_coord     <= it.v;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (it.op == OP_WRITE) begin
			texels[it.idx]  = {it.a, it.b, it.g, it.r};
			written[it.idx] = 1'b1;
		end else if (it.typed) begin
			pending.push_back(it.want);
		end else begin
			pending.push_back(filter_texel(it.u, it.v));
		end
	endtask

	function automatic vec_t rand_vec(opcode_t op);
		vec_t it;
		it.op    = op;
		it.idx   = 16'($urandom);
		it.r     = 8'($urandom);
		it.g     = 8'($urandom);
		it.b     = 8'($urandom);
		it.a     = 8'($urandom);
		it.u     = 24'($urandom);
		it.v     = 24'($urandom);
		it.typed = 1'b0;
		return it;
	endfunction

	// fills any texel the sample would read before issuing it
	task automatic sample_at(logic [23:0] u, logic [23:0] v);
		int x, y, n;
		longint fu, fv;
		logic [15:0] addr;
		vec_t it;
		base_texel(u, v, x, y, fu, fv);
		for (n = 0; n < (bilin_r ? 4 : 1); n++) begin
			if (corner_addr(n, x, y, addr) && !written[addr]) begin
				it     = rand_vec(OP_WRITE);
				it.idx = addr;
				send_item(it);
			end
		end
		it   = rand_vec(OP_SAMPLE);
		it.u = u;
		it.v = v;
		send_item(it);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TEX_WIDTH:     width_r = val;
			REG_TEX_HEIGHT:    height_r = val;
			REG_HAS_ALPHA:     alpha_r = val[0];
			REG_WRAP_MODE:     wrap_r = val[0];
			REG_BILINEAR_MODE: bilin_r = val[0];
			default: ;
		endcase
	endtask

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			n_fail++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending.size() == 0) begin
				$error("result with no item pending");
				n_fail++;
			end else begin
				texel8p8_t w;
				w = pending.pop_front();
				check_field("out_red", w.r, out_red);
				check_field("out_green", w.g, out_green);
				check_field("out_blue", w.b, out_blue);
				check_field("out_alpha", w.a, out_alpha);
			end
		end
	end

	initial begin
		logic [8:0] dims_w [8];
		logic [8:0] dims_h [8];
		logic [23:0] u, v;
		int p, i;
		dims_w = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd3, 9'd256, 9'd2, 9'd1};
		dims_h = '{9'd1, 9'd256, 9'd0, 9'd2, 9'd511, 9'd1, 9'd5, 9'd256};
		n_fail = 0;
		no_gaps = 1'b0;
		width_r = 9'd1;
		height_r = 9'd1;
		alpha_r = 1'b1;
		wrap_r = 1'b1;
		bilin_r = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_WRITE;
		texel_index = '0;
		{in_red, in_green, in_blue, in_alpha} = '0;
		u_coord = '0;
		v_coord = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (i = 0; i < MEM_DEPTH; i++)
			written[i] = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_reg(REG_SPARE, 9'h1FF);
		foreach (directed[k])
			send_item(directed[k]);
		wait_idle();

		for (p = 0; p < 8; p++) begin
			if (p >= 4) begin
				dims_w[p] = 9'($urandom_range(0, 511));
				dims_h[p] = 9'($urandom_range(1, 8));
			end
			set_reg(REG_TEX_WIDTH, dims_w[p]);
			set_reg(REG_TEX_HEIGHT, dims_h[p]);
			set_reg(REG_HAS_ALPHA, 9'(p & 1));
			set_reg(REG_WRAP_MODE, 9'((p >> 1) & 1));
			set_reg(REG_BILINEAR_MODE, 9'(((p >> 2) & 1) ^ 1));
			no_gaps = (p % 3 == 1);
			for (i = 0; i < 25; i++) begin
				if ($urandom_range(0, 4) == 0) begin
					send_item(rand_vec(OP_WRITE));
				end else begin
					u = 24'($urandom);
					v = 24'($urandom);
					case ($urandom_range(0, 5))
						0: u[15:0] = 16'h0000;
						1: v[15:0] = 16'hFFFF;
						2: u = {8'h00, u[15:0]};
						default: ;
					endcase
					sample_at(u, v);
				end
			end
			wait_idle();
		end

		if (n_fail == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
